/* rtl/led_matrix_bitplane_scanner_defines.svh */
// Assertion macros shared by the scanner RTL.
// Both take i_clk and i_rst_n from the module that uses them.
`ifndef LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH
`define LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define LMBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmbs assertion failed");
`define LMBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmbs assertion failed");
`else
`define LMBS_ASSERT_IMP(label, ante, cons)
`define LMBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/lmbs_pkg.sv */
// Types, constants and helpers of the LED matrix bit-plane scanner.
// No dependencies.
package lmbs_pkg;

    localparam int PLANE_COUNT_DEF   = 3;
    localparam int ROW_COUNT_DEF     = 8;
    localparam int BYTES_PER_ROW_DEF = 2;

    localparam int CMD_W      = 1;
    localparam int PLANE_W    = 2;
    localparam int ROW_W      = 3;
    localparam int BYTE_W     = 3;
    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CMP_W      = 8;

    localparam logic [CMP_W-1:0] INITIAL_COMPARE_RST = 8'h20;
    localparam logic [CMP_W-1:0] PLANE0_COMPARE_RST  = 8'd8;
    localparam logic [CMP_W-1:0] PLANE1_COMPARE_RST  = 8'd13;
    localparam logic [CMP_W-1:0] PLANE2_COMPARE_RST  = 8'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_ENABLE     = 3'd0,
        CFG_INITIAL_COMPARE = 3'd1,
        CFG_PLANE0_COMPARE  = 3'd2,
        CFG_PLANE1_COMPARE  = 3'd3,
        CFG_PLANE2_COMPARE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_READ,
        SH_LOAD,
        SH_SHIFT
    } t_sh_state;

    // row request from the timer to the row shifter
    typedef struct packed {
        logic               start;
        logic [PLANE_W-1:0] plane;
        logic [ROW_W-1:0]   row;
    } t_row_req;

    function automatic int unsigned store_index(input int unsigned plane,
                                                input int unsigned row,
                                                input int unsigned bsel,
                                                input int unsigned rows,
                                                input int unsigned bytes);
        return (plane * rows + row) * bytes + bsel;
    endfunction

endpackage

/* rtl/lmbs_if.sv */
// Channel interfaces of the scanner: input items, column bits, config writes.
// Depends on lmbs_pkg.
interface lmbs_in_if;
    logic                         valid;
    logic                         ready;
    logic [lmbs_pkg::CMD_W-1:0]   cmd;
    logic [lmbs_pkg::PLANE_W-1:0] plane_sel;
    logic [lmbs_pkg::ROW_W-1:0]   row_sel;
    logic [lmbs_pkg::BYTE_W-1:0]  byte_sel;
    logic [lmbs_pkg::DATA_W-1:0]  pixel_byte;

    modport source (output valid, cmd, plane_sel, row_sel, byte_sel, pixel_byte,
                    input ready);
    modport sink   (input valid, cmd, plane_sel, row_sel, byte_sel, pixel_byte,
                    output ready);
endinterface

interface lmbs_out_if;
    logic                       valid;
    logic                       ready;
    logic [lmbs_pkg::ROW_W-1:0] row_drive;
    logic                       column_bit;
    logic                       unblank;

    modport source (output valid, row_drive, column_bit, unblank, input ready);
    modport sink   (input valid, row_drive, column_bit, unblank, output ready);
endinterface

interface lmbs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lmbs_pkg::CFG_IDX_W-1:0]  index;
    logic [lmbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/led_matrix_bitplane_scanner.sv */
// Bit-plane LED matrix scanner. A write word or a tick that does not match the
// compare value is accepted whenever no row is being shown. A matching tick
// shows one row: for each byte the frame store is read, the shift register
// loaded and the byte's 8 bits shifted out, stalling while the sink is not ready.
// The next word is accepted the cycle after the last bit is taken. Synchronous
// active-low reset clears the frame store valid bits at once; no clearing pass.
`include "led_matrix_bitplane_scanner_defines.svh"
module led_matrix_bitplane_scanner #(
    parameter int PLANE_COUNT   = lmbs_pkg::PLANE_COUNT_DEF,
    parameter int ROW_COUNT     = lmbs_pkg::ROW_COUNT_DEF,
    parameter int BYTES_PER_ROW = lmbs_pkg::BYTES_PER_ROW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmbs_in_if.sink    i_item,
    lmbs_out_if.source o_bit,
    lmbs_cfg_if.sink   i_cfg
);

    localparam int DEPTH = PLANE_COUNT * ROW_COUNT * BYTES_PER_ROW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = lmbs_pkg::CMP_W;

    logic                         r_scan_enable,     n_scan_enable;
    logic [CW-1:0]                r_initial_compare, n_initial_compare;
    logic [CW-1:0]                r_plane0_compare,  n_plane0_compare;
    logic [CW-1:0]                r_plane1_compare,  n_plane1_compare;
    logic [CW-1:0]                r_plane2_compare,  n_plane2_compare;
    logic [CW-1:0]                r_tick,            n_tick;
    logic [CW-1:0]                r_compare,         n_compare;
    logic [lmbs_pkg::ROW_W-1:0]   r_scan_row,        n_scan_row;
    logic [lmbs_pkg::PLANE_W-1:0] r_scan_plane,      n_scan_plane;

    logic                        busy;
    logic                        item_acc;
    logic                        cfg_acc;
    logic                        tick_hit;
    logic                        match;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [lmbs_pkg::DATA_W-1:0] rd_data;
    lmbs_pkg::t_row_req          row_req;

    assign i_item.ready = !busy;
    assign i_cfg.ready  = 1'b1;
    assign item_acc     = i_item.valid && i_item.ready;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;

    assign tick_hit = item_acc && (i_item.cmd == lmbs_pkg::CMD_TICK) && r_scan_enable;
    assign match    = tick_hit && (r_tick == r_compare);

    // drop writes outside the configured frame
    assign wr_en = item_acc && (i_item.cmd == lmbs_pkg::CMD_WRITE)
                   && (int'(i_item.plane_sel) < PLANE_COUNT)
                   && (int'(i_item.row_sel) < ROW_COUNT)
                   && (int'(i_item.byte_sel) < BYTES_PER_ROW);
    assign wr_addr = AW'(lmbs_pkg::store_index(int'(i_item.plane_sel), int'(i_item.row_sel),
                                               int'(i_item.byte_sel),
                                               ROW_COUNT, BYTES_PER_ROW));

    assign row_req.start = match;
    assign row_req.plane = r_scan_plane;
    assign row_req.row   = r_scan_row;

    always_comb begin
        n_scan_enable     = r_scan_enable;
        n_initial_compare = r_initial_compare;
        n_plane0_compare  = r_plane0_compare;
        n_plane1_compare  = r_plane1_compare;
        n_plane2_compare  = r_plane2_compare;
        n_tick            = r_tick;
        n_compare         = r_compare;
        n_scan_row        = r_scan_row;
        n_scan_plane      = r_scan_plane;

        if (tick_hit) begin
            if (match) begin
                n_tick = '0;
                // load the plane period at the top row
                if (r_scan_row == '0) begin
                    unique case (r_scan_plane)
                        2'd0:    n_compare = r_plane0_compare;
                        2'd1:    n_compare = r_plane1_compare;
                        2'd2:    n_compare = r_plane2_compare;
                        default: n_compare = r_compare;
                    endcase
                end
                if (r_scan_row == lmbs_pkg::ROW_W'(ROW_COUNT - 1)) begin
                    n_scan_row = '0;
                    if (r_scan_plane == lmbs_pkg::PLANE_W'(PLANE_COUNT - 1)) begin
                        n_scan_plane = '0;
                    end else begin
                        n_scan_plane = r_scan_plane + lmbs_pkg::PLANE_W'(1);
                    end
                end else begin
                    n_scan_row = r_scan_row + lmbs_pkg::ROW_W'(1);
                end
            end else begin
                n_tick = r_tick + CW'(1);
            end
        end

        if (cfg_acc) begin
            unique case (i_cfg.index)
                lmbs_pkg::CFG_SCAN_ENABLE: begin
                    // restart the timer on a rising enable
                    if (i_cfg.data[0] && !r_scan_enable) begin
                        n_tick    = '0;
                        n_compare = r_initial_compare;
                    end
                    n_scan_enable = i_cfg.data[0];
                end
                lmbs_pkg::CFG_INITIAL_COMPARE: n_initial_compare = i_cfg.data;
                lmbs_pkg::CFG_PLANE0_COMPARE:  n_plane0_compare  = i_cfg.data;
                lmbs_pkg::CFG_PLANE1_COMPARE:  n_plane1_compare  = i_cfg.data;
                lmbs_pkg::CFG_PLANE2_COMPARE:  n_plane2_compare  = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable     <= 1'b0;
            r_initial_compare <= lmbs_pkg::INITIAL_COMPARE_RST;
            r_plane0_compare  <= lmbs_pkg::PLANE0_COMPARE_RST;
            r_plane1_compare  <= lmbs_pkg::PLANE1_COMPARE_RST;
            r_plane2_compare  <= lmbs_pkg::PLANE2_COMPARE_RST;
            r_tick            <= '0;
            r_compare         <= lmbs_pkg::INITIAL_COMPARE_RST;
            r_scan_row        <= '0;
            r_scan_plane      <= '0;
        end else begin
            r_scan_enable     <= n_scan_enable;
            r_initial_compare <= n_initial_compare;
            r_plane0_compare  <= n_plane0_compare;
            r_plane1_compare  <= n_plane1_compare;
            r_plane2_compare  <= n_plane2_compare;
            r_tick            <= n_tick;
            r_compare         <= n_compare;
            r_scan_row        <= n_scan_row;
            r_scan_plane      <= n_scan_plane;
        end
    end

    lmbs_frame_store #(
        .PLANE_COUNT   (PLANE_COUNT),
        .ROW_COUNT     (ROW_COUNT),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_item.pixel_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    lmbs_row_shifter #(
        .PLANE_COUNT   (PLANE_COUNT),
        .ROW_COUNT     (ROW_COUNT),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_row_shifter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (row_req),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_bit     (o_bit)
    );

    `LMBS_ASSERT_NXT(a_match_starts_row, match, busy)
    `LMBS_ASSERT_IMP(a_no_input_while_shifting, o_bit.valid, !i_item.ready)
    `LMBS_ASSERT_IMP(a_row_in_range, 1'b1, r_scan_row <= lmbs_pkg::ROW_W'(ROW_COUNT - 1))
    `LMBS_ASSERT_IMP(a_plane_in_range, 1'b1, r_scan_plane <= lmbs_pkg::PLANE_W'(PLANE_COUNT - 1))

endmodule

/* rtl/lmbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lmbs_frame_store.sv */
// Frame store: bit-plane pixel bytes in a RAM, with one valid bit per byte
// so that bytes never written since reset read as zero. Uses lmbs_ram.
module lmbs_frame_store #(
    parameter int PLANE_COUNT   = lmbs_pkg::PLANE_COUNT_DEF,
    parameter int ROW_COUNT     = lmbs_pkg::ROW_COUNT_DEF,
    parameter int BYTES_PER_ROW = lmbs_pkg::BYTES_PER_ROW_DEF,
    localparam int DEPTH = PLANE_COUNT * ROW_COUNT * BYTES_PER_ROW,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [lmbs_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [lmbs_pkg::DATA_W-1:0] o_rdata
);

    logic [DEPTH-1:0]            r_valid;
    logic                        r_rd_valid;
    logic [lmbs_pkg::DATA_W-1:0] ram_rdata;

    lmbs_ram #(
        .WIDTH (lmbs_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? ram_rdata : '0;

endmodule

/* rtl/lmbs_row_shifter.sv */
// Row shifter: fetches one row's bytes, last byte first, and shifts them out
// one column bit per word through an output register. Depends on lmbs_pkg.
`include "led_matrix_bitplane_scanner_defines.svh"
module lmbs_row_shifter #(
    parameter int PLANE_COUNT   = lmbs_pkg::PLANE_COUNT_DEF,
    parameter int ROW_COUNT     = lmbs_pkg::ROW_COUNT_DEF,
    parameter int BYTES_PER_ROW = lmbs_pkg::BYTES_PER_ROW_DEF,
    localparam int DEPTH = PLANE_COUNT * ROW_COUNT * BYTES_PER_ROW,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmbs_pkg::t_row_req          i_req,
    output logic                        o_busy,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [lmbs_pkg::DATA_W-1:0] i_rd_data,
    lmbs_out_if.source                  o_bit
);

    localparam int BW        = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int BIT_CNT_W = $clog2(lmbs_pkg::DATA_W);

    lmbs_pkg::t_sh_state r_state, n_state;

    logic [lmbs_pkg::PLANE_W-1:0] r_plane;
    logic [lmbs_pkg::ROW_W-1:0]   r_row;
    logic [BW-1:0]                r_byte;
    logic [lmbs_pkg::DATA_W-1:0]  r_sr;
    logic [BIT_CNT_W-1:0]         r_bit_cnt;
    logic                         r_out_valid;
    logic                         r_out_bit;
    logic                         r_out_unblank;
    logic [lmbs_pkg::ROW_W-1:0]   r_out_row;

    logic out_take;
    logic load_sr;
    logic byte_end;

    assign byte_end = (r_bit_cnt == BIT_CNT_W'(lmbs_pkg::DATA_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmbs_pkg::SH_IDLE: begin
                if (i_req.start) begin
                    n_state = lmbs_pkg::SH_READ;
                end
            end
            lmbs_pkg::SH_READ:  n_state = lmbs_pkg::SH_LOAD;
            lmbs_pkg::SH_LOAD:  n_state = lmbs_pkg::SH_SHIFT;
            lmbs_pkg::SH_SHIFT: begin
                if (out_take && byte_end) begin
                    n_state = (r_byte == '0) ? lmbs_pkg::SH_IDLE : lmbs_pkg::SH_READ;
                end
            end
            default: n_state = lmbs_pkg::SH_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_rd_en  = 1'b0;
        load_sr  = 1'b0;
        out_take = 1'b0;
        unique case (r_state)
            lmbs_pkg::SH_IDLE:  ;
            lmbs_pkg::SH_READ:  o_rd_en = 1'b1;
            lmbs_pkg::SH_LOAD:  load_sr = 1'b1;
            lmbs_pkg::SH_SHIFT: out_take = !r_out_valid || o_bit.ready;
            default: ;
        endcase
    end

    assign o_rd_addr = AW'(lmbs_pkg::store_index(int'(r_plane), int'(r_row), int'(r_byte),
                                                 ROW_COUNT, BYTES_PER_ROW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmbs_pkg::SH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_take) begin
                r_out_valid <= 1'b1;
            end else if (o_bit.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lmbs_pkg::SH_IDLE && i_req.start) begin
            r_plane <= i_req.plane;
            r_row   <= i_req.row;
            r_byte  <= BW'(BYTES_PER_ROW - 1);
        end
        if (load_sr) begin
            r_sr      <= i_rd_data;
            r_bit_cnt <= '0;
        end
        if (out_take) begin
            r_sr          <= r_sr << 1;
            r_bit_cnt     <= r_bit_cnt + BIT_CNT_W'(1);
            r_out_bit     <= r_sr[lmbs_pkg::DATA_W-1];
            r_out_unblank <= byte_end && (r_byte == '0);
            r_out_row     <= r_row;
            // step to the next lower byte after its last bit
            if (byte_end && r_byte != '0) begin
                r_byte <= r_byte - BW'(1);
            end
        end
    end

    assign o_bit.valid      = r_out_valid;
    assign o_bit.column_bit = r_out_bit;
    assign o_bit.unblank    = r_out_unblank;
    assign o_bit.row_drive  = r_out_row;
    assign o_busy           = (r_state != lmbs_pkg::SH_IDLE) || r_out_valid;

    `LMBS_ASSERT_IMP(a_start_when_idle, i_req.start, (r_state == lmbs_pkg::SH_IDLE) && !r_out_valid)
    `LMBS_ASSERT_NXT(a_start_reads, i_req.start, r_state == lmbs_pkg::SH_READ)
    `LMBS_ASSERT_NXT(a_unblank_ends_row, o_bit.valid && o_bit.ready && o_bit.unblank, !o_bit.valid)

endmodule

/* dv/tb.sv */
// Self-checking bench for led_matrix_bitplane_scanner: frame writes, timer ticks and
// register writes go in, and each serial column bit is checked against a local scan model.
// Depends on lmbs_pkg, the lmbs_*_if interfaces and the scanner RTL.
module tb;
    import lmbs_pkg::*;

    localparam int PLANES          = PLANE_COUNT_DEF;
    localparam int ROWS            = ROW_COUNT_DEF;
    localparam int BYTES           = BYTES_PER_ROW_DEF;
    localparam int SETTLE_CYCLES   = BYTES * 10 + 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED_LAST  = 3'd7;
    localparam logic [CFG_DATA_W-1:0] SCAN_OFF           = 8'h00;
    localparam logic [CFG_DATA_W-1:0] SCAN_ON            = 8'h01;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             data;
        logic             unblank;
    } t_col_bit;

    logic clk;
    logic rst_n;

    lmbs_in_if  item_ch ();
    lmbs_out_if bit_ch ();
    lmbs_cfg_if cfg_ch ();

    led_matrix_bitplane_scanner DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_ch),
        .o_bit   (bit_ch),
        .i_cfg   (cfg_ch)
    );

    // scan model state
    logic [DATA_W-1:0]  frame_bytes [PLANES][ROWS][BYTES];
    logic               scan_on;
    logic [CMP_W-1:0]   start_cmp;
    logic [CMP_W-1:0]   plane_cmp [PLANES];
    logic [CMP_W-1:0]   tick_cnt;
    logic [CMP_W-1:0]   cur_cmp;
    logic [ROW_W-1:0]   cur_row;
    logic [PLANE_W-1:0] cur_plane;

    t_col_bit pending_bits [$];
    t_col_bit want;

    int  mismatch_count;
    int  words_in;
    int  bits_checked;
    int  cfg_writes;
    int  rows_shown;
    int  idle_cycles;
    bit  idle_on;
    bit  stall_on;
    bit  hold_off_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic reset_scan_model();
        for (int p = 0; p < PLANES; p++)
            for (int r = 0; r < ROWS; r++)
                for (int b = 0; b < BYTES; b++)
                    frame_bytes[p][r][b] = '0;
        scan_on      = 1'b0;
        start_cmp    = INITIAL_COMPARE_RST;
        plane_cmp[0] = PLANE0_COMPARE_RST;
        plane_cmp[1] = PLANE1_COMPARE_RST;
        plane_cmp[2] = PLANE2_COMPARE_RST;
        tick_cnt     = '0;
        cur_cmp      = INITIAL_COMPARE_RST;
        cur_row      = '0;
        cur_plane    = '0;
    endtask

    function automatic void track_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_SCAN_ENABLE: begin
                // a rising enable restarts the timer from the start compare value
                if (value[0] && !scan_on) begin
                    tick_cnt = '0;
                    cur_cmp  = start_cmp;
                end
                scan_on = value[0];
            end
            CFG_INITIAL_COMPARE: start_cmp    = value;
            CFG_PLANE0_COMPARE:  plane_cmp[0] = value;
            CFG_PLANE1_COMPARE:  plane_cmp[1] = value;
            CFG_PLANE2_COMPARE:  plane_cmp[2] = value;
            default: ;
        endcase
    endfunction

    function automatic void predict_column_bits(input t_cmd cmd,
                                                input logic [PLANE_W-1:0] plane,
                                                input logic [ROW_W-1:0] row,
                                                input logic [BYTE_W-1:0] bsel,
                                                input logic [DATA_W-1:0] pix);
        t_col_bit cb;
        int       b;
        int       x;
        if (cmd == CMD_WRITE) begin
            // drop writes outside the configured store
            if (plane < PLANES && row < ROWS && bsel < BYTES)
                frame_bytes[plane][row][bsel] = pix;
            return;
        end
        if (!scan_on)
            return;
        if (tick_cnt != cur_cmp) begin
            tick_cnt = tick_cnt + CMP_W'(1);
            return;
        end
        tick_cnt = '0;
        if (cur_row == 0)
            cur_cmp = plane_cmp[cur_plane];
        for (b = BYTES - 1; b >= 0; b--) begin
            for (x = DATA_W - 1; x >= 0; x--) begin
                cb.row     = cur_row;
                cb.data    = frame_bytes[cur_plane][cur_row][b][x];
                cb.unblank = (b == 0 && x == 0);
                pending_bits.push_back(cb);
            end
        end
        rows_shown++;
        if (cur_row == ROWS - 1) begin
            cur_row   = '0;
            cur_plane = (cur_plane == PLANES - 1) ? PLANE_W'(0) : cur_plane + PLANE_W'(1);
        end else begin
            cur_row = cur_row + ROW_W'(1);
        end
    endfunction

    // model update on accepted words and column bit check, both sampled at the edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                track_cfg_write(cfg_ch.index, cfg_ch.data);
                cfg_writes++;
            end
            if (item_ch.valid && item_ch.ready) begin
                predict_column_bits(t_cmd'(item_ch.cmd), item_ch.plane_sel, item_ch.row_sel,
                                    item_ch.byte_sel, item_ch.pixel_byte);
                words_in++;
            end
            if (bit_ch.valid && bit_ch.ready) begin
                if (pending_bits.size() == 0) begin
                    report_mismatch($sformatf("unexpected column bit row=%0d bit=%0b unblank=%0b",
                                              bit_ch.row_drive, bit_ch.column_bit,
                                              bit_ch.unblank));
                end else begin
                    want = pending_bits.pop_front();
                    if (bit_ch.row_drive !== want.row)
                        report_mismatch($sformatf("row_drive got %0d exp %0d",
                                                  bit_ch.row_drive, want.row));
                    if (bit_ch.column_bit !== want.data)
                        report_mismatch($sformatf("column_bit got %0b exp %0b (row %0d)",
                                                  bit_ch.column_bit, want.data, want.row));
                    if (bit_ch.unblank !== want.unblank)
                        report_mismatch($sformatf("unblank got %0b exp %0b (row %0d)",
                                                  bit_ch.unblank, want.unblank, want.row));
                    bits_checked++;
                end
            end
        end
    end

    // column bit receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_off_req) begin
                bit_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                bit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                bit_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (bit_ch.valid && bit_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d column bits outstanding",
                 WATCHDOG_LIMIT, pending_bits.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input t_cmd cmd, input logic [PLANE_W-1:0] plane,
                             input logic [ROW_W-1:0] row, input logic [BYTE_W-1:0] bsel,
                             input logic [DATA_W-1:0] pix);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= cmd;
        item_ch.plane_sel  <= plane;
        item_ch.row_sel    <= row;
        item_ch.byte_sel   <= bsel;
        item_ch.pixel_byte <= pix;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // tick words carry random address and data bits, which the block ignores
    task automatic send_tick();
        send_item(CMD_TICK, PLANE_W'($urandom), ROW_W'($urandom), BYTE_W'($urandom),
                  DATA_W'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the input, wait out every column bit, then let a row in flight finish
    task automatic wait_scan_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_scan(input logic [CMP_W-1:0] init_cmp, input logic [CMP_W-1:0] p0,
                                input logic [CMP_W-1:0] p1, input logic [CMP_W-1:0] p2);
        cfg_write(CFG_SCAN_ENABLE, SCAN_OFF);
        cfg_write(CFG_INITIAL_COMPARE, init_cmp);
        cfg_write(CFG_PLANE0_COMPARE, p0);
        cfg_write(CFG_PLANE1_COMPARE, p1);
        cfg_write(CFG_PLANE2_COMPARE, p2);
        cfg_write(CFG_SCAN_ENABLE, SCAN_ON);
    endtask

    task automatic test_disabled_scan();
        send_tick();
        send_item(CMD_WRITE, 2'd0, 3'd0, 3'd0, 8'h5A);
        send_item(CMD_WRITE, 2'd0, 3'd0, 3'd1, 8'hA5);
        send_item(CMD_WRITE, 2'd2, 3'd7, 3'd1, 8'hFF);
        send_item(CMD_WRITE, 2'd1, 3'd3, 3'd0, 8'h00);
        // out of range addresses must leave the store alone
        send_item(CMD_WRITE, 2'd3, 3'd0, 3'd0, 8'hFF);
        send_item(CMD_WRITE, 2'd0, 3'd0, 3'd2, 8'hFF);
        send_item(CMD_WRITE, 2'd0, 3'd7, 3'd7, 8'hC3);
        send_tick();
        wait_scan_idle();
        for (int i = CFG_UNMAPPED_FIRST; i <= CFG_UNMAPPED_LAST; i++)
            cfg_write(CFG_IDX_W'(i), 8'hFF);
    endtask

    task automatic test_scan_start();
        program_scan(8'd0, 8'd0, 8'd1, 8'd2);
        send_tick();
        send_tick();
        wait_scan_idle();
        // enable while running and a new start compare: neither may disturb the timer
        cfg_write(CFG_SCAN_ENABLE, 8'hFF);
        cfg_write(CFG_INITIAL_COMPARE, 8'd5);
        repeat (3) send_tick();
        wait_scan_idle();
        cfg_write(CFG_SCAN_ENABLE, SCAN_OFF);
        send_tick();
        wait_scan_idle();
        cfg_write(CFG_SCAN_ENABLE, SCAN_ON);
        repeat (6) send_tick();
        wait_scan_idle();
    endtask

    task automatic test_output_hold_off();
        program_scan(8'd0, 8'd0, 8'd0, 8'd0);
        hold_off_req = 1'b1;
        repeat (12) send_tick();
        send_item(CMD_WRITE, 2'd1, 3'd5, 3'd1, 8'h3C);
        repeat (4) send_tick();
        wait_scan_idle();
    endtask

    // a full 256-tick interval: the count must reach 255 and then match
    task automatic test_longest_interval();
        program_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 256; i++) begin
            if (i % 128 == 0)
                send_item(CMD_WRITE, PLANE_W'($urandom_range(0, PLANES - 1)),
                          ROW_W'($urandom), BYTE_W'($urandom_range(0, BYTES - 1)),
                          DATA_W'($urandom));
            send_tick();
        end
        wait_scan_idle();
        cfg_write(CFG_SCAN_ENABLE, SCAN_OFF);
    endtask

    task automatic run_random_traffic(input int n_items);
        int kind;
        for (int i = 0; i < n_items; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                send_tick();
            else if (kind < 9)
                send_item(CMD_WRITE, PLANE_W'($urandom_range(0, PLANES - 1)),
                          ROW_W'($urandom), BYTE_W'($urandom_range(0, BYTES - 1)),
                          DATA_W'($urandom));
            else
                send_item(CMD_WRITE, PLANE_W'($urandom), ROW_W'($urandom),
                          BYTE_W'($urandom), DATA_W'($urandom));
        end
        wait_scan_idle();
    endtask

    initial begin
        mismatch_count = 0;
        words_in       = 0;
        bits_checked   = 0;
        cfg_writes     = 0;
        rows_shown     = 0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        hold_off_req   = 1'b0;
        reset_scan_model();

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_WRITE;
        item_ch.plane_sel  <= '0;
        item_ch.row_sel    <= '0;
        item_ch.byte_sel   <= '0;
        item_ch.pixel_byte <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_SCAN_ENABLE;
        cfg_ch.data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_scan();
        test_scan_start();
        test_output_hold_off();
        test_longest_interval();

        program_scan(8'd1, 8'd0, 8'd2, 8'd1);
        run_random_traffic(10);
        program_scan(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
        run_random_traffic(10);

        // closing stretch runs at full rate on both sides, the input still held while a row is shown
        idle_on  = 1'b0;
        stall_on = 1'b0;
        program_scan(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
        run_random_traffic(12);

        if (pending_bits.size() != 0)
            report_mismatch($sformatf("%0d column bits never arrived", pending_bits.size()));
        $display("Run covered %0d input words and %0d register writes;", words_in, cfg_writes);
        $display("%0d rows shown, %0d column bits compared", rows_shown, bits_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lmbs_pkg.sv
rtl/lmbs_if.sv
rtl/lmbs_ram.sv
rtl/lmbs_frame_store.sv
rtl/lmbs_row_shifter.sv
rtl/led_matrix_bitplane_scanner.sv
dv/tb.sv
